FILE: src/gdm_pkg.sv
// Shared widths, codes and control/status types of the grid mass deposit block
`default_nettype none

package gdm_pkg;

    localparam int POS_W     = 32;
    localparam int VAL_W     = 32;
    localparam int WGT_W     = 31;
    localparam int IDX_W     = 15;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam int FLD_W     = 32;
    localparam int WSUM_W    = 47;
    localparam int SUM_W     = 48;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 240;
    localparam int OUT_TDATA_W = 144;

    localparam logic [OP_W-1:0] OP_DEPOSIT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [ST_W-1:0] ST_DEPOSITED  = 3'd0;
    localparam logic [ST_W-1:0] ST_OUTSIDE    = 3'd1;
    localparam logic [ST_W-1:0] ST_READ_NORM  = 3'd2;
    localparam logic [ST_W-1:0] ST_READ_EMPTY = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOSIT_SCHEME = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_MODE    = 3'd7;

    localparam logic [CFG_W-1:0] SCALE_RST = 32'h0010_0000;

    typedef struct packed {
        logic [WSUM_W-1:0]       wsum;
        logic signed [SUM_W-1:0] sz;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sx;
    } t_cell;

    typedef struct packed {
        logic       load;
        logic       map_mul;
        logic       map_chk;
        logic       nb_adv;
        logic       w_mul;
        logic [1:0] w_sel;
        logic       rd_cell;
        logic       wr_cell;
        logic       rd_idx;
        logic       rd_latch;
        logic       div_step;
        logic       sweep_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic outside;
        logic axis_last;
        logic nb_valid;
        logic nb_last;
        logic rd_direct;
        logic div_last;
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/gdm_ram.sv
// Generic single write port, single read port RAM with registered read data
`default_nettype none

module gdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/gdm_ctrl.sv
// Controller state machine sequencing deposit, read, clear and result hand-off
`default_nettype none

module gdm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [gdm_pkg::OP_W-1:0]  i_op,
    output logic                      o_ready,
    input  gdm_pkg::t_sts             i_sts,
    output gdm_pkg::t_cmd             o_cmd
);
    import gdm_pkg::*;

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MMUL  = 4'd2;
    localparam logic [3:0] S_MCHK  = 4'd3;
    localparam logic [3:0] S_NB    = 4'd4;
    localparam logic [3:0] S_W1    = 4'd5;
    localparam logic [3:0] S_W2    = 4'd6;
    localparam logic [3:0] S_W3    = 4'd7;
    localparam logic [3:0] S_RDC   = 4'd8;
    localparam logic [3:0] S_WRC   = 4'd9;
    localparam logic [3:0] S_RIDX  = 4'd10;
    localparam logic [3:0] S_RLAT  = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_emit, n_emit;
    logic       accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        o_cmd   = '0;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = r_emit ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        OP_DEPOSIT: n_state = S_MMUL;
                        OP_READ:    n_state = S_RIDX;
                        OP_CLEAR: begin
                            n_state = S_SWEEP;
                            n_emit  = 1'b1;
                        end
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_MMUL: begin
                o_cmd.map_mul = 1'b1;
                n_state = S_MCHK;
            end
            S_MCHK: begin
                o_cmd.map_chk = 1'b1;
                if (i_sts.axis_last) begin
                    n_state = i_sts.outside ? S_DONE : S_NB;
                end else begin
                    n_state = S_MMUL;
                end
            end
            S_NB: begin
                if (i_sts.nb_valid) begin
                    n_state = S_W1;
                end else if (i_sts.nb_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.nb_adv = 1'b1;
                end
            end
            S_W1: begin
                o_cmd.w_mul = 1'b1;
                o_cmd.w_sel = 2'd0;
                n_state = S_W2;
            end
            S_W2: begin
                o_cmd.w_mul = 1'b1;
                o_cmd.w_sel = 2'd1;
                n_state = S_W3;
            end
            S_W3: begin
                o_cmd.w_mul = 1'b1;
                o_cmd.w_sel = 2'd2;
                n_state = S_RDC;
            end
            S_RDC: begin
                o_cmd.rd_cell = 1'b1;
                n_state = S_WRC;
            end
            S_WRC: begin
                o_cmd.wr_cell = 1'b1;
                if (i_sts.nb_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.nb_adv = 1'b1;
                    n_state = S_NB;
                end
            end
            S_RIDX: begin
                o_cmd.rd_idx = 1'b1;
                n_state = S_RLAT;
            end
            S_RLAT: begin
                o_cmd.rd_latch = 1'b1;
                n_state = i_sts.rd_direct ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_emit  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

endmodule

`default_nettype wire

FILE: src/gdm_dpath.sv
// Datapath: grid mapping, trilinear weights, cell accumulate, read divide, result register
`default_nettype none

module gdm_dpath #(
    parameter int GRID_X    = 32,
    parameter int GRID_Y    = 32,
    parameter int GRID_Z    = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic [gdm_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [gdm_pkg::CFG_W-1:0]                   i_cfg_wdata,
    input  gdm_pkg::t_cmd                               i_cmd,
    output gdm_pkg::t_sts                               o_sts,
    input  logic [gdm_pkg::OP_W-1:0]                    i_op,
    input  logic [gdm_pkg::POS_W-1:0]                   i_pos_x,
    input  logic [gdm_pkg::POS_W-1:0]                   i_pos_y,
    input  logic [gdm_pkg::POS_W-1:0]                   i_pos_z,
    input  logic signed [gdm_pkg::VAL_W-1:0]            i_value_x,
    input  logic signed [gdm_pkg::VAL_W-1:0]            i_value_y,
    input  logic signed [gdm_pkg::VAL_W-1:0]            i_value_z,
    input  logic [gdm_pkg::WGT_W-1:0]                   i_sample_weight,
    input  logic [gdm_pkg::IDX_W-1:0]                   i_cell_index,
    input  logic                                        i_out_ready,
    output logic                                        o_out_valid,
    output logic [gdm_pkg::ST_W-1:0]                    o_status,
    output logic [gdm_pkg::FLD_W-1:0]                   o_field_x,
    output logic [gdm_pkg::FLD_W-1:0]                   o_field_y,
    output logic [gdm_pkg::FLD_W-1:0]                   o_field_z,
    output logic [gdm_pkg::WSUM_W-1:0]                  o_weight_sum,
    output logic                                        o_ram_we,
    output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0]     o_ram_waddr,
    output gdm_pkg::t_cell                              o_ram_wdata,
    output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0]     o_ram_raddr,
    input  gdm_pkg::t_cell                              i_ram_rdata
);
    import gdm_pkg::*;

    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(CELLS);
    localparam int GMXY  = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int GMAX  = (GMXY > GRID_Z) ? GMXY : GRID_Z;
    localparam int BW    = $clog2(GMAX + 2);
    localparam int GW    = BW + FRAC_BITS;
    localparam int FW    = FRAC_BITS + 1;
    localparam int SH    = 36 - FRAC_BITS;
    localparam int IXW   = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int PW    = WGT_W + FW;

    localparam logic [GW-1:0] ONE_G  = GW'(64'd1 << FRAC_BITS);
    localparam logic [GW-1:0] HALF_G = GW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [FW-1:0] ONE_F  = FW'(64'd1 << FRAC_BITS);
    localparam logic [BW-1:0] N_AX [3] = '{BW'(GRID_X), BW'(GRID_Y), BW'(GRID_Z)};
    localparam logic [AW-1:0] GY_A = AW'(GRID_Y);
    localparam logic [AW-1:0] GZ_A = AW'(GRID_Z);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [WSUM_W-1:0] WMAX = '1;

    // configuration
    logic [CFG_W-1:0] r_org [3];
    logic [CFG_W-1:0] r_scl [3];
    logic             r_scheme;
    logic             r_vec;

    // latched word
    logic [OP_W-1:0]              r_op;
    logic [POS_W-1:0]             r_pos [3];
    logic signed [VAL_W-1:0]      r_val [3];
    logic [WGT_W-1:0]             r_wgt;
    logic [IDX_W-1:0]             r_idx;

    // grid mapping
    logic [1:0]          r_axis;
    logic                r_neg;
    logic                r_zs;
    logic [47:0]         r_ph;
    logic [47:0]         r_pl;
    logic                r_out;
    logic [BW-1:0]       r_base [3];
    logic [FRAC_BITS-1:0] r_t [3];

    // neighbor walk and accumulate
    logic [2:0]              r_nb;
    logic [AW-1:0]           r_addr;
    logic [WGT_W-1:0]        r_wacc;
    logic signed [SUM_W-1:0] r_inc [3];

    // read and divide
    logic signed [SUM_W-1:0] r_rs [3];
    logic [WSUM_W-1:0]       r_rw;
    logic                    r_sneg [3];
    logic                    r_ovf [3];
    logic [WSUM_W-1:0]       r_rem [3];
    logic [31:0]             r_lo [3];
    logic [31:0]             r_q [3];
    logic [4:0]              r_dcnt;

    // clearing pass
    logic [AW-1:0] r_swp;

    // result register
    logic                 r_ovalid;
    logic [ST_W-1:0]      r_ost;
    logic [FLD_W-1:0]     r_ofx, r_ofy, r_ofz;
    logic [WSUM_W-1:0]    r_ows;

    function automatic logic signed [SUM_W-1:0] sat_add48(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] t;
        t = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (t[SUM_W] != t[SUM_W-1]) begin
            sat_add48 = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat_add48 = t[SUM_W-1:0];
        end
    endfunction

    function automatic logic [FLD_W-1:0] sat32(input logic signed [SUM_W-1:0] s);
        logic hi_ones;
        logic hi_zero;
        hi_ones = &s[SUM_W-1:FLD_W-1];
        hi_zero = ~|s[SUM_W-1:FLD_W-1];
        if (hi_ones || hi_zero) begin
            sat32 = s[FLD_W-1:0];
        end else begin
            sat32 = s[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    endfunction

    // grid mapping arithmetic
    logic [32:0]   diff;
    logic [63:0]   msum, mv, mlim;
    logic          ph_ovf, inside_now;
    logic [GW-1:0] g_now, u_now;

    always_comb begin
        diff       = {r_pos[r_axis][31], r_pos[r_axis]} - {r_org[r_axis][31], r_org[r_axis]};
        msum       = {r_ph, 16'b0} + {16'b0, r_pl};
        mv         = msum >> SH;
        mlim       = 64'(N_AX[r_axis]) << FRAC_BITS;
        ph_ovf     = |r_ph[47:40];
        inside_now = r_neg ? r_zs : (!ph_ovf && (mv < mlim));
        g_now      = r_neg ? '0 : mv[GW-1:0];
        u_now      = g_now + (r_scheme ? HALF_G : ONE_G);
    end

    // neighbor terms
    logic [BW-1:0] ni [3];
    logic [BW-1:0] nc [3];
    logic [FW-1:0] nf [3];
    logic          nv [3];
    logic [AW-1:0] n_addr;

    always_comb begin
        logic nd;
        for (int a = 0; a < 3; a++) begin
            nd    = r_nb[2-a];
            ni[a] = r_base[a] + BW'(nd);
            nv[a] = (ni[a] != '0) && (ni[a] <= N_AX[a]);
            nc[a] = ni[a] - BW'(1);
            nf[a] = nd ? FW'(r_t[a]) : (ONE_F - FW'(r_t[a]));
        end
        n_addr = (AW'(nc[0]) * GY_A + AW'(nc[1])) * GZ_A + AW'(nc[2]);
    end

    logic [WGT_W-1:0] wa;
    logic [PW-1:0]    wprod;

    assign wa    = (i_cmd.w_sel == 2'd0) ? r_wgt : r_wacc;
    assign wprod = PW'(wa) * PW'(nf[i_cmd.w_sel]);

    logic signed [63:0] vprod [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            vprod[a] = $signed({1'b0, r_wacc}) * r_val[a];
        end
    end

    // accumulate
    t_cell         new_cell;
    logic [SUM_W-1:0] nwsum;

    always_comb begin
        nwsum          = {1'b0, i_ram_rdata.wsum} + SUM_W'(r_wacc);
        new_cell.wsum  = nwsum[SUM_W-1] ? WMAX : nwsum[WSUM_W-1:0];
        new_cell.sx    = sat_add48(i_ram_rdata.sx, r_inc[0]);
        new_cell.sy    = r_vec ? sat_add48(i_ram_rdata.sy, r_inc[1]) : i_ram_rdata.sy;
        new_cell.sz    = r_vec ? sat_add48(i_ram_rdata.sz, r_inc[2]) : i_ram_rdata.sz;
    end

    // read address range
    logic [IXW-1:0] idx_ext;
    logic           in_rng;

    assign idx_ext = IXW'(r_idx);
    assign in_rng  = idx_ext < IXW'(CELLS);

    // divider setup and step
    logic signed [SUM_W-1:0] rd_s [3];
    logic [SUM_W-1:0]        rd_m [3];
    logic [WSUM_W:0]         rem2 [3];
    logic                    ge [3];
    logic [31:0]             qc [3];
    logic [FLD_W-1:0]        div_out [3];
    logic [FLD_W-1:0]        raw_out [3];

    always_comb begin
        rd_s[0] = i_ram_rdata.sx;
        rd_s[1] = i_ram_rdata.sy;
        rd_s[2] = i_ram_rdata.sz;
        for (int a = 0; a < 3; a++) begin
            rd_m[a] = rd_s[a][SUM_W-1] ? SUM_W'(-rd_s[a]) : SUM_W'(rd_s[a]);
            rem2[a] = {r_rem[a], r_lo[a][31]};
            ge[a]   = rem2[a] >= {1'b0, r_rw};
            if (r_sneg[a]) begin
                qc[a]      = (r_ovf[a] || (r_q[a] > 32'h8000_0000)) ? 32'h8000_0000 : r_q[a];
                div_out[a] = 32'(-qc[a]);
            end else begin
                qc[a]      = r_q[a];
                div_out[a] = (r_ovf[a] || r_q[a][31]) ? 32'h7FFF_FFFF : r_q[a];
            end
            raw_out[a] = sat32(r_rs[a]);
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.outside    = r_out | !inside_now;
        o_sts.axis_last  = (r_axis == 2'd2);
        o_sts.nb_valid   = nv[0] && nv[1] && nv[2];
        o_sts.nb_last    = !r_scheme || (r_nb == 3'd7);
        o_sts.rd_direct  = !in_rng || (i_ram_rdata.wsum == '0);
        o_sts.div_last   = (r_dcnt == 5'd31);
        o_sts.sweep_last = (r_swp == LAST_CELL);
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    // memory port
    always_comb begin
        o_ram_we    = i_cmd.sweep_step | i_cmd.wr_cell;
        o_ram_waddr = i_cmd.sweep_step ? r_swp : r_addr;
        o_ram_wdata = i_cmd.sweep_step ? '0 : new_cell;
        o_ram_raddr = i_cmd.rd_idx ? idx_ext[AW-1:0] : r_addr;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_org[a] <= '0;
                r_scl[a] <= SCALE_RST;
            end
            r_scheme <= 1'b0;
            r_vec    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:       r_org[0] <= i_cfg_wdata;
                CFG_ORIGIN_Y:       r_org[1] <= i_cfg_wdata;
                CFG_ORIGIN_Z:       r_org[2] <= i_cfg_wdata;
                CFG_SCALE_X:        r_scl[0] <= i_cfg_wdata;
                CFG_SCALE_Y:        r_scl[1] <= i_cfg_wdata;
                CFG_SCALE_Z:        r_scl[2] <= i_cfg_wdata;
                CFG_DEPOSIT_SCHEME: r_scheme <= i_cfg_wdata[0];
                CFG_VECTOR_MODE:    r_vec    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp    <= '0;
            r_axis   <= '0;
            r_nb     <= '0;
            r_dcnt   <= '0;
            r_out    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_swp  <= '0;
                r_axis <= '0;
                r_nb   <= '0;
                r_out  <= 1'b0;
            end
            if (i_cmd.sweep_step) begin
                r_swp <= r_swp + AW'(1);
            end
            if (i_cmd.map_chk) begin
                r_axis <= r_axis + 2'd1;
                r_out  <= r_out | !inside_now;
            end
            if (i_cmd.nb_adv) begin
                r_nb <= r_nb + 3'd1;
            end
            if (i_cmd.rd_latch) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_val[0] <= i_value_x;
            r_val[1] <= i_value_y;
            r_val[2] <= i_value_z;
            r_wgt    <= i_sample_weight;
            r_idx    <= i_cell_index;
        end
        if (i_cmd.map_mul) begin
            r_neg <= diff[32];
            r_zs  <= (r_scl[r_axis] == '0);
            r_ph  <= 48'(diff[31:16]) * 48'(r_scl[r_axis]);
            r_pl  <= 48'(diff[15:0]) * 48'(r_scl[r_axis]);
        end
        if (i_cmd.map_chk) begin
            r_base[r_axis] <= u_now[GW-1:FRAC_BITS];
            r_t[r_axis]    <= r_scheme ? u_now[FRAC_BITS-1:0] : '0;
        end
        if (i_cmd.w_mul) begin
            r_wacc <= WGT_W'(wprod >> FRAC_BITS);
            if (i_cmd.w_sel == 2'd0) begin
                r_addr <= n_addr;
            end
        end
        if (i_cmd.rd_cell) begin
            for (int a = 0; a < 3; a++) begin
                r_inc[a] <= vprod[a][63:16];
            end
        end
        if (i_cmd.rd_latch) begin
            r_rw <= i_ram_rdata.wsum;
            for (int a = 0; a < 3; a++) begin
                r_rs[a]   <= rd_s[a];
                r_sneg[a] <= rd_s[a][SUM_W-1];
                r_ovf[a]  <= WSUM_W'(rd_m[a][SUM_W-1:16]) >= i_ram_rdata.wsum;
                r_rem[a]  <= WSUM_W'(rd_m[a][SUM_W-1:16]);
                r_lo[a]   <= {rd_m[a][15:0], 16'b0};
                r_q[a]    <= '0;
            end
        end else if (i_cmd.div_step) begin
            for (int a = 0; a < 3; a++) begin
                r_rem[a] <= ge[a] ? WSUM_W'(rem2[a] - {1'b0, r_rw}) : rem2[a][WSUM_W-1:0];
                r_lo[a]  <= {r_lo[a][30:0], 1'b0};
                r_q[a]   <= {r_q[a][30:0], ge[a]};
            end
        end
        if (i_cmd.out_load) begin
            r_ofx <= '0;
            r_ofy <= '0;
            r_ofz <= '0;
            r_ows <= '0;
            case (r_op)
                OP_DEPOSIT: r_ost <= r_out ? ST_OUTSIDE : ST_DEPOSITED;
                OP_READ: begin
                    if (!in_rng) begin
                        r_ost <= ST_READ_EMPTY;
                    end else if (r_rw == '0) begin
                        r_ost <= ST_READ_EMPTY;
                        r_ofx <= raw_out[0];
                        r_ofy <= raw_out[1];
                        r_ofz <= raw_out[2];
                    end else begin
                        r_ost <= ST_READ_NORM;
                        r_ofx <= div_out[0];
                        r_ofy <= div_out[1];
                        r_ofz <= div_out[2];
                        r_ows <= r_rw;
                    end
                end
                OP_CLEAR:   r_ost <= ST_CLEARED;
                default:    r_ost <= ST_OUTSIDE;
            endcase
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ost;
    assign o_field_x    = r_ofx;
    assign o_field_y    = r_ofy;
    assign o_field_z    = r_ofz;
    assign o_weight_sum = r_ows;

endmodule

`default_nettype wire

FILE: src/grid_mass_deposit_ngp_cic.sv
// Top level of the grid mass deposit block (NGP and CIC) over one accumulator RAM
// Deposit: each axis is mapped (multiply, then range check), then per neighbor: walk, three
// weight multiplies, RAM read, RAM write. Read: an in-range, non-empty cell goes through a
// 32-step divider. Clear: zeroes all GRID_X*GRID_Y*GRID_Z cells before its result loads.
// Flow: one word in flight; the next word can be taken in the cycle after the result loads.
// Reset: synchronous, active low; then a clearing pass over all GRID_X*GRID_Y*GRID_Z cells, input held.
`default_nettype none

module grid_mass_deposit_ngp_cic #(
    parameter int GRID_X    = 32,
    parameter int GRID_Y    = 32,
    parameter int GRID_Z    = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pos_x, pos_y, pos_z, value_x, value_y, value_z, sample_weight, cell_index
    input  logic [gdm_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // op
    input  logic [gdm_pkg::OP_W-1:0]            i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // field_x, field_y, field_z, weight_sum
    output logic [gdm_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // status
    output logic [gdm_pkg::ST_W-1:0]            o_m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [gdm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gdm_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import gdm_pkg::*;

    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(CELLS);

    t_cmd cmd;
    t_sts sts;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_cell         ram_wdata, ram_rdata;

    logic [FLD_W-1:0]  field_x, field_y, field_z;
    logic [WSUM_W-1:0] weight_sum;

    gdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tuser),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gdm_dpath #(
        .GRID_X    (GRID_X),
        .GRID_Y    (GRID_Y),
        .GRID_Z    (GRID_Z),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_s_axis_tuser),
        .i_pos_x         (i_s_axis_tdata[31:0]),
        .i_pos_y         (i_s_axis_tdata[63:32]),
        .i_pos_z         (i_s_axis_tdata[95:64]),
        .i_value_x       (i_s_axis_tdata[127:96]),
        .i_value_y       (i_s_axis_tdata[159:128]),
        .i_value_z       (i_s_axis_tdata[191:160]),
        .i_sample_weight (i_s_axis_tdata[222:192]),
        .i_cell_index    (i_s_axis_tdata[237:223]),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_status        (o_m_axis_tuser),
        .o_field_x       (field_x),
        .o_field_y       (field_y),
        .o_field_z       (field_z),
        .o_weight_sum    (weight_sum),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata)
    );

    gdm_ram #(
        .WIDTH ($bits(t_cell)),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tdata = {1'b0, weight_sum, field_z, field_y, field_x};

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_cell && cmd.sweep_step))
        else $error("cell update during clearing pass");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result overwrites an untaken word");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second word taken while one is in flight");

    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_cell |=> cmd.wr_cell)
        else $error("cell read not followed by its write");

endmodule

`default_nettype wire
